@@ sv/mcwd_pkg.sv @@
package mcwd_pkg;

  // Table size and time width
  localparam int SLOTS     = 128;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_AGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_AGE = 2'd1;
  localparam logic [15:0] WARN_AGE_RESET   = 16'd50;
  localparam logic [15:0] EXPIRE_AGE_RESET = 16'd60;

  // Byte that arms a magic close ('V')
  localparam logic [7:0] MAGIC_BYTE = 8'h56;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_DATA    = 2'd2,
    ACT_HANGUP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_DISABLED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WS_NONE    = 2'd0,
    WS_WARNED  = 2'd1,
    WS_AVERTED = 2'd2
  } ws_t;

  typedef struct packed {
    action_t    action;
    logic [6:0] client_slot;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] granted_slot;
    logic       keepalive;
    logic [7:0] warnings_new;
    logic [7:0] averted_new;
    logic       expired;
    logic       updates_on;
    logic [7:0] active_clients;
  } out_item_t;

  typedef struct packed {
    logic [15:0] warn_age;
    logic [15:0] expire_age;
  } cfg_t;

  // One slot table entry
  typedef struct packed {
    logic [TIME_BITS-1:0] last_pet;
    ws_t                  warn;
    logic                 magic;
  } slot_rec_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_rec_t         data;
  } ram_wr_t;

endpackage

@@ sv/mcwd_slot_ram.sv @@
module mcwd_slot_ram (
  input  logic                        clk,
  input  mcwd_pkg::ram_wr_t           wr,
  input  logic [mcwd_pkg::SLOT_W-1:0] rd_addr,
  output mcwd_pkg::slot_rec_t         rd_data
);

  mcwd_pkg::slot_rec_t mem [mcwd_pkg::SLOTS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/mcwd_ctrl.sv @@
module mcwd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  mcwd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mcwd_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mcwd_pkg::out_item_t         out_data,
  output mcwd_pkg::ram_wr_t           wr,
  output logic [mcwd_pkg::SLOT_W-1:0] rd_addr,
  input  mcwd_pkg::slot_rec_t         rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_WALK,
    S_TICK_DRAIN,
    S_CONN_SCAN,
    S_CLI_EVAL,
    S_RESP
  } state_t;

  state_t                           state;
  mcwd_pkg::in_item_t               item;
  mcwd_pkg::out_item_t              res;
  logic [mcwd_pkg::SLOT_W-1:0]      idx;
  logic                             p_v;
  logic [mcwd_pkg::SLOT_W-1:0]      p_idx;
  logic [mcwd_pkg::TIME_BITS-1:0]   now;
  logic                             upd;
  logic [mcwd_pkg::SLOTS-1:0]       in_use;
  logic [mcwd_pkg::CNT_W-1:0]       count;
  logic [mcwd_pkg::CNT_W-1:0]       warns;
  logic [mcwd_pkg::CNT_W-1:0]       averts;
  logic                             exp_seen;

  logic [mcwd_pkg::SLOT_W-1:0]      in_idx;
  logic [mcwd_pkg::SLOT_W-1:0]      item_idx;
  logic                             in_slot_ok;
  logic [mcwd_pkg::TIME_BITS-1:0]   age;
  logic                             le_warn;
  logic                             active;
  logic                             avert;
  logic                             warn_new;
  logic                             exp_hit;
  mcwd_pkg::ws_t                    ws1;
  mcwd_pkg::ws_t                    ws2;
  logic [mcwd_pkg::CNT_W-1:0]       warns_next;
  logic [mcwd_pkg::CNT_W-1:0]       averts_next;
  logic                             upd_next;
  logic                             exp_next;
  logic [mcwd_pkg::CNT_W-1:0]       count_dec;

  assign in_ready   = (state == S_IDLE);
  assign in_idx     = mcwd_pkg::SLOT_W'(in_data.client_slot);
  assign item_idx   = mcwd_pkg::SLOT_W'(item.client_slot);
  assign in_slot_ok = (int'(in_data.client_slot) < mcwd_pkg::SLOTS) && in_use[in_idx];
  assign count_dec  = (count != '0) ? count - 1'b1 : count;

  // Read address: requested slot while idle, walk index otherwise
  assign rd_addr = (state == S_IDLE) ? in_idx : idx;

  // Shared age unit: one subtract and two compares per slot
  always_comb begin
    age      = now - rd_data.last_pet;
    le_warn  = (age <= mcwd_pkg::TIME_BITS'(cfg.warn_age));
    active   = p_v && in_use[p_idx];
    avert    = active && (rd_data.warn == mcwd_pkg::WS_WARNED) && le_warn;
    ws1      = avert ? mcwd_pkg::WS_AVERTED : rd_data.warn;
    warn_new = active && (ws1 != mcwd_pkg::WS_WARNED) && !le_warn;
    ws2      = warn_new ? mcwd_pkg::WS_WARNED : ws1;
    exp_hit  = active && (age > mcwd_pkg::TIME_BITS'(cfg.expire_age));
    warns_next  = warns + mcwd_pkg::CNT_W'(warn_new);
    averts_next = averts + mcwd_pkg::CNT_W'(avert);
    upd_next    = upd && !exp_hit;
    exp_next    = exp_seen || exp_hit;
  end

  // Table write port
  always_comb begin
    wr = '0;
    unique case (state)
      S_TICK_WALK, S_TICK_DRAIN: begin
        wr.en            = active;
        wr.addr          = p_idx;
        wr.data.last_pet = rd_data.last_pet;
        wr.data.warn     = ws2;
        wr.data.magic    = rd_data.magic;
      end
      S_CONN_SCAN: begin
        wr.en            = !in_use[idx];
        wr.addr          = idx;
        wr.data.last_pet = now;
        wr.data.warn     = mcwd_pkg::WS_NONE;
        wr.data.magic    = 1'b0;
      end
      S_CLI_EVAL: begin
        wr.addr      = item_idx;
        wr.data.warn = rd_data.warn;
        if (item.action == mcwd_pkg::ACT_DATA) begin
          wr.en            = 1'b1;
          wr.data.last_pet = now;
          wr.data.magic    = (item.data_byte == mcwd_pkg::MAGIC_BYTE);
        end else begin
          wr.en            = rd_data.magic;
          wr.data.last_pet = '0;
          wr.data.magic    = 1'b0;
        end
      end
      default: wr = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      now       <= '0;
      upd       <= 1'b1;
      in_use    <= '0;
      count     <= '0;
      p_v       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item                <= in_data;
            idx                 <= '0;
            p_v                 <= 1'b0;
            warns               <= '0;
            averts              <= '0;
            exp_seen            <= 1'b0;
            res                 <= '0;
            res.updates_on      <= upd;
            res.active_clients  <= 8'(count);
            if (in_data.action == mcwd_pkg::ACT_TICK) begin
              now <= now + 1'b1;
              if (upd) begin
                state <= S_TICK_WALK;
              end else begin
                res.status <= mcwd_pkg::ST_DISABLED;
                state      <= S_RESP;
              end
            end else if (!upd) begin
              res.status <= mcwd_pkg::ST_DISABLED;
              state      <= S_RESP;
            end else if (in_data.action == mcwd_pkg::ACT_CONNECT) begin
              state <= S_CONN_SCAN;
            end else if (!in_slot_ok) begin
              res.status <= mcwd_pkg::ST_NOT_ACTIVE;
              state      <= S_RESP;
            end else begin
              state <= S_CLI_EVAL;
            end
          end
        end
        S_TICK_WALK: begin
          p_v      <= 1'b1;
          p_idx    <= idx;
          warns    <= warns_next;
          averts   <= averts_next;
          upd      <= upd_next;
          exp_seen <= exp_next;
          if (idx == mcwd_pkg::SLOT_LAST) begin
            state <= S_TICK_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK_DRAIN: begin
          p_v                <= 1'b0;
          upd                <= upd_next;
          res.status         <= upd_next ? mcwd_pkg::ST_OK : mcwd_pkg::ST_DISABLED;
          res.keepalive      <= upd_next;
          res.warnings_new   <= 8'(warns_next);
          res.averted_new    <= 8'(averts_next);
          res.expired        <= exp_next;
          res.updates_on     <= upd_next;
          state              <= S_RESP;
        end
        S_CONN_SCAN: begin
          if (!in_use[idx]) begin
            in_use[idx]        <= 1'b1;
            count              <= count + 1'b1;
            res.status         <= mcwd_pkg::ST_OK;
            res.granted_slot   <= 7'(idx);
            res.active_clients <= 8'(count + 1'b1);
            state              <= S_RESP;
          end else if (idx == mcwd_pkg::SLOT_LAST) begin
            res.status <= mcwd_pkg::ST_TABLE_FULL;
            state      <= S_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CLI_EVAL: begin
          if (item.action == mcwd_pkg::ACT_HANGUP) begin
            if (rd_data.magic) begin
              in_use[item_idx]   <= 1'b0;
              count              <= count_dec;
              res.active_clients <= 8'(count_dec);
            end else begin
              upd            <= 1'b0;
              res.status     <= mcwd_pkg::ST_DISABLED;
              res.updates_on <= 1'b0;
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/multi_client_watchdog_mux.sv @@
// Data byte and hang-up: the item passes through S_CLI_EVAL and then S_RESP, which registers the result beat.
// Refused items (slot not active, updates off): the item goes straight to S_RESP for its result beat.
// Connect: one table slot scanned per cycle for a free entry.
// Tick: with updates on, one slot aged per cycle by the shared unit.
// One item in flight; the result register lets the next item enter while a beat waits.
// Synchronous reset: time 0, table empty, updates on, ages 50/60; entries stay unwritten.
module multi_client_watchdog_mux (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mcwd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mcwd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  mcwd_pkg::cfg_t                cfg;
  mcwd_pkg::ram_wr_t             wr;
  logic [mcwd_pkg::SLOT_W-1:0]   rd_addr;
  mcwd_pkg::slot_rec_t           rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_age   <= mcwd_pkg::WARN_AGE_RESET;
      cfg.expire_age <= mcwd_pkg::EXPIRE_AGE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mcwd_pkg::REG_WARN_AGE:   cfg.warn_age   <= cfg_data;
        mcwd_pkg::REG_EXPIRE_AGE: cfg.expire_age <= cfg_data;
        default: ;
      endcase
    end
  end

  mcwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  mcwd_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ sv/mcwd_checker.sv @@
module mcwd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input mcwd_pkg::out_item_t            out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // Keepalive only while updates stay enabled
  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.keepalive |->
      out_data.updates_on && (out_data.status == mcwd_pkg::ST_OK))
    else $error("keepalive with updates off");

  // Expiry latches updates off
  a_expire: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.expired |-> !out_data.updates_on)
    else $error("expiry reported with updates still on");

  // Full table means every slot is in use
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == mcwd_pkg::ST_TABLE_FULL) |->
      (out_data.active_clients == 8'(mcwd_pkg::SLOTS)))
    else $error("table full with free slots");

endmodule

bind multi_client_watchdog_mux mcwd_checker u_chk (.*);
